/* src/multi_alarm_clock_with_snooze_assert.svh */
// Assertion macros for the multi-alarm clock block.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef MULTI_ALARM_CLOCK_WITH_SNOOZE_ASSERT_SVH
`define MULTI_ALARM_CLOCK_WITH_SNOOZE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define MACS_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted
`define MACS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/macs_pkg.sv */
// Shared types and constants of the multi-alarm clock block.
// No dependencies; used by every module of the block.
package macs_pkg;

  // Input transaction selector carried on in_tuser
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_ADD  = 1'b1;

  // Result kind carried on out_tuser
  typedef enum logic [1:0] {
    KIND_TRIGGER = 2'd0,
    KIND_ADDED   = 2'd1,
    KIND_FULL    = 2'd2
  } kind_t;

  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int SLOT_W    = 4;
  localparam int MASK_W    = 16;
  localparam int RES_CNT_W = 5;

  localparam logic [RES_CNT_W-1:0] RESULT_LIMIT     = 5'd16;
  localparam logic [MIN_W:0]       SNOOZE_STEP      = 7'd10;
  localparam logic [MIN_W:0]       MINUTES_PER_HOUR = 7'd60;
  localparam logic [HOUR_W-1:0]    LAST_HOUR        = 5'd23;
  localparam logic [MIN_W-1:0]     LAST_MINUTE      = 6'd59;

  // One alarm table entry; slot validity follows from the fill count
  typedef struct packed {
    logic              active;
    logic              snz;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
  } entry_t;

  // One result transaction
  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic              snz;
    logic              last;
  } result_t;

endpackage

/* src/macs_alarm_mem.sv */
// Alarm table storage: one write port, one read port, registered read data.
// Depends on macs_pkg for the entry type.
module macs_alarm_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  macs_pkg::entry_t   wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output macs_pkg::entry_t   rdata
);

  macs_pkg::entry_t mem [DEPTH];
  macs_pkg::entry_t rdata_r;

  // Write entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read entry, hold data while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/macs_out_reg.sv */
// Output register of the result channel: parts the scan engine from the receiver.
// Depends on macs_pkg for the result type.
module macs_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  macs_pkg::result_t push_data,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output macs_pkg::result_t out_data
);

  logic              valid_r;
  macs_pkg::result_t data_r;

  // Load a new transaction or drop the one taken by the receiver
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* src/multi_alarm_clock_with_snooze.sv */
// Multi-alarm clock with snooze: top level, sequencer and table scan.
// Depends on macs_pkg, macs_alarm_mem, macs_out_reg and the assertion header.
//
// Usage: each input transaction (in_*) is a minute tick (in_tuser = 0) or an
// alarm add (in_tuser = 1). An add is accepted, held in a pending register
// and then handed as its single result (added or table full) to the output
// register. A tick reads every filled slot of the alarm table from a
// registered-read memory, one slot a cycle unless the output stalls,
// compares it to the current time, writes it back (snoozed or disabled at
// midnight) and emits one trigger transaction per match; the final one
// carries out_tlast. A tick with no match emits nothing. A tick walks the
// alarm table once through its single read port.
// One item is worked at a time; in_tready rises again once the last result
// sits in the output register, which holds it until the receiver takes it.
// When out_tready is low the scan stalls on its next match and resumes
// without loss. Reset (rst_n low, synchronous) sets the time to 00:00 and
// empties the table; no clearing pass is needed.
`include "multi_alarm_clock_with_snooze_assert.svh"

module multi_alarm_clock_with_snooze #(
  parameter int MAX_ALARMS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [4:0] alarm_hour, [10:5] alarm_minute, [11] alarm_snoozeable,
  // [27:12] snooze_mask, [31:28] zero
  input  logic [31:0] in_tdata,
  // [0] mode
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] slot, [8:4] fire_hour, [14:9] fire_minute, [15] asks_snooze
  output logic [15:0] out_tdata,
  // [1:0] kind
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  localparam int IW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
  localparam int CW = $clog2(MAX_ALARMS + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ALARMS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // Input fields
  logic [macs_pkg::HOUR_W-1:0] in_hour;
  logic [macs_pkg::MIN_W-1:0]  in_minute;
  logic                        in_snz;
  logic [macs_pkg::MASK_W-1:0] in_mask;

  assign in_hour   = in_tdata[4:0];
  assign in_minute = in_tdata[10:5];
  assign in_snz    = in_tdata[11];
  assign in_mask   = in_tdata[27:12];

  // Registers
  state_t                         state_r, state_nxt;
  logic [macs_pkg::HOUR_W-1:0]    hour_r, hour_nxt;
  logic [macs_pkg::MIN_W-1:0]     min_r, min_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [macs_pkg::MASK_W-1:0]    mask_r, mask_nxt;
  logic [CW-1:0]                  rd_idx_r, rd_idx_nxt;
  logic                           ev_v_r, ev_v_nxt;
  logic [IW-1:0]                  ev_idx_r, ev_idx_nxt;
  logic                           pend_v_r, pend_v_nxt;
  macs_pkg::result_t              pend_r, pend_nxt;
  logic [macs_pkg::RES_CNT_W-1:0] n_r, n_nxt;

  // Memory and output register connections
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  macs_pkg::entry_t  mem_wdata;
  logic              rd_en;
  logic [IW-1:0]     raddr;
  macs_pkg::entry_t  rd_data;
  logic              push;
  macs_pkg::result_t push_data;
  logic              out_free;
  macs_pkg::result_t out_res;

  macs_alarm_mem #(
    .DEPTH (MAX_ALARMS),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rd_data)
  );

  macs_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {out_res.snz, out_res.minute, out_res.hour, out_res.slot};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

  assign in_tready = (state_r == ST_IDLE);

  // Evaluate the slot whose data arrives this cycle
  logic                       day_wrap;
  logic                       ev_match;
  logic                       ev_report;
  logic                       ev_snooze;
  logic                       stall;
  logic                       scan_done;
  logic [macs_pkg::MIN_W:0]   snz_sum;
  logic                       snz_roll;
  logic [macs_pkg::MIN_W-1:0]  snz_min;
  logic [macs_pkg::HOUR_W-1:0] snz_hour;
  macs_pkg::entry_t           wb_entry;
  macs_pkg::result_t          trig_res;

  always_comb begin
    day_wrap  = (hour_r == macs_pkg::LAST_HOUR) && (min_r == macs_pkg::LAST_MINUTE);
    ev_match  = ev_v_r && rd_data.active && (rd_data.hour == hour_r) &&
                (rd_data.minute == min_r);
    ev_report = ev_match && (n_r < macs_pkg::RESULT_LIMIT);
    stall     = ev_report && pend_v_r && !out_free;
    ev_snooze = ev_match && rd_data.snz && (32'(ev_idx_r) < macs_pkg::MASK_W) &&
                mask_r[4'(ev_idx_r)];

    // Move ten minutes later, wrapping the hour and the day
    snz_sum  = {1'b0, rd_data.minute} + macs_pkg::SNOOZE_STEP;
    snz_roll = (snz_sum >= macs_pkg::MINUTES_PER_HOUR);
    snz_min  = snz_roll ? 6'(snz_sum - macs_pkg::MINUTES_PER_HOUR) : 6'(snz_sum);
    if (!snz_roll) begin
      snz_hour = rd_data.hour;
    end else if (rd_data.hour == macs_pkg::LAST_HOUR) begin
      snz_hour = '0;
    end else begin
      snz_hour = rd_data.hour + 5'd1;
    end

    wb_entry        = rd_data;
    wb_entry.active = rd_data.active && !(day_wrap && rd_data.snz);
    if (ev_snooze) begin
      wb_entry.hour   = snz_hour;
      wb_entry.minute = snz_min;
    end

    trig_res        = '0;
    trig_res.kind   = macs_pkg::KIND_TRIGGER;
    trig_res.slot   = 4'(ev_idx_r);
    trig_res.hour   = rd_data.hour;
    trig_res.minute = rd_data.minute;
    trig_res.snz    = rd_data.snz;

    rd_en     = (state_r == ST_SCAN) && !stall && (rd_idx_r < count_r);
    raddr     = rd_idx_r[IW-1:0];
    scan_done = (state_r == ST_SCAN) && (rd_idx_r == count_r) && !ev_v_r;
  end

  // Sequencer next values
  always_comb begin
    state_nxt  = state_r;
    hour_nxt   = hour_r;
    min_nxt    = min_r;
    count_nxt  = count_r;
    mask_nxt   = mask_r;
    rd_idx_nxt = rd_idx_r;
    ev_v_nxt   = ev_v_r;
    ev_idx_nxt = ev_idx_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    n_nxt      = n_r;
    mem_we     = 1'b0;
    mem_waddr  = ev_idx_r;
    mem_wdata  = wb_entry;
    push       = 1'b0;
    push_data  = pend_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mask_nxt = in_mask;
          if (in_tuser == macs_pkg::MODE_ADD) begin
            pend_nxt   = '0;
            pend_v_nxt = 1'b1;
            state_nxt  = ST_FLUSH;
            if (count_r < COUNT_MAX) begin
              // Store in the next free slot
              mem_we           = 1'b1;
              mem_waddr        = count_r[IW-1:0];
              mem_wdata.active = 1'b1;
              mem_wdata.snz    = in_snz;
              mem_wdata.hour   = in_hour;
              mem_wdata.minute = in_minute;
              pend_nxt.kind    = macs_pkg::KIND_ADDED;
              pend_nxt.slot    = 4'(count_r);
              count_nxt        = count_r + 1'b1;
            end else begin
              pend_nxt.kind = macs_pkg::KIND_FULL;
            end
          end else begin
            rd_idx_nxt = '0;
            n_nxt      = '0;
            state_nxt  = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (!stall) begin
          ev_v_nxt   = rd_en;
          ev_idx_nxt = raddr;
          if (rd_en) begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
          // Write back the evaluated slot
          mem_we = ev_v_r;
          if (ev_report) begin
            if (pend_v_r) begin
              push           = 1'b1;
              push_data.last = 1'b0;
            end
            pend_nxt   = trig_res;
            pend_v_nxt = 1'b1;
            n_nxt      = n_r + 1'b1;
          end
        end
        if (scan_done) begin
          // Advance the clock by one minute
          if (min_r == macs_pkg::LAST_MINUTE) begin
            min_nxt  = '0;
            hour_nxt = (hour_r == macs_pkg::LAST_HOUR) ? '0 : hour_r + 5'd1;
          end else begin
            min_nxt = min_r + 6'd1;
          end
          state_nxt = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          push           = 1'b1;
          push_data.last = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hour_r   <= '0;
      min_r    <= '0;
      count_r  <= '0;
      rd_idx_r <= '0;
      ev_v_r   <= 1'b0;
      pend_v_r <= 1'b0;
      n_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      hour_r   <= hour_nxt;
      min_r    <= min_nxt;
      count_r  <= count_nxt;
      rd_idx_r <= rd_idx_nxt;
      ev_v_r   <= ev_v_nxt;
      pend_v_r <= pend_v_nxt;
      n_r      <= n_nxt;
      mask_r   <= mask_nxt;
      ev_idx_r <= ev_idx_nxt;
      pend_r   <= pend_nxt;
    end
  end

  // Checks
  `MACS_ASSERT_HOLDS(a_idle_no_pending, in_tready, !pend_v_r, "result still pending while idle")
  `MACS_ASSERT_NEXT(a_full_keeps_count, in_tvalid && in_tready && (in_tuser == macs_pkg::MODE_ADD) && (count_r == COUNT_MAX), $stable(count_r), "add to full table changed count")
  `MACS_ASSERT_HOLDS(a_no_rw_same_slot, ev_v_r && rd_en, ev_idx_r != raddr, "write-back and read hit one slot")
  `MACS_ASSERT_HOLDS(a_push_when_free, push, out_free, "result pushed into a full output register")

endmodule
